>>> rtl/core/cau_pkg.sv
// shared types, constants and step functions of the complex arithmetic unit
`default_nettype none

package cau_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int SQRT_STEPS       = 32;
  localparam int FRONT_STAGES     = 4;
  localparam int CORDIC_W         = 34;

  localparam logic [63:0] PI_Q61            = 64'h6487ED5110B4611A;
  localparam logic [63:0] TWO_PI_Q61        = 64'hC90FDAA22168C235;
  localparam logic [63:0] HALF_PI_Q61       = 64'h3243F6A8885A308D;
  localparam logic [63:0] THREE_HALF_PI_Q61 = TWO_PI_Q61 - HALF_PI_Q61;

  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sh0_26DD3B6A;

  typedef enum logic [2:0] {
    FUNC_MAG   = 3'd0,
    FUNC_CONJ  = 3'd1,
    FUNC_MUL   = 3'd2,
    FUNC_DIV   = 3'd3,
    FUNC_ADD   = 3'd4,
    FUNC_SCALE = 3'd5,
    FUNC_EXP   = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_DIV0 = 2'd2
  } status_e;

  // operands after the multiply and sum stages, in sign-magnitude form
  typedef struct packed {
    func_e       func;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    logic [63:0] den;
    logic        den_zero;
    logic        ang_neg;
    logic [31:0] ang_mag;
  } fr_t;

  // one restoring step: {subtracted, new remainder}
  function automatic logic [64:0] rem_step(input logic [63:0] rem, input logic bit_in,
                                           input logic [63:0] den);
    logic [64:0] sh;
    logic        take;
    sh = {rem, bit_in};
    take = (sh >= {1'b0, den});
    rem_step = {take, take ? 64'(sh - {1'b0, den}) : sh[63:0]};
  endfunction

  function automatic logic signed [CORDIC_W-1:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    atan_q30 = signed'(34'(v));
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cau_front.sv
// input register, operand multipliers, sums and sign-magnitude conversion
`default_nettype none

module cau_front (
  input  logic                clk,
  input  logic [2:0]          func,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  input  logic signed [31:0]  scale,
  input  logic signed [31:0]  angle,
  output cau_pkg::fr_t        fr
);

  cau_pkg::func_e       s0_func;
  logic signed [31:0]   s0_a_re, s0_a_im, s0_b_re, s0_b_im, s0_scale, s0_angle;

  cau_pkg::func_e       s1_func;
  logic signed [31:0]   s1_a_re, s1_a_im, s1_b_re, s1_b_im, s1_angle;
  logic signed [63:0]   s1_p0, s1_p1, s1_p2, s1_p3, s1_p4, s1_p5;
  logic signed [31:0]   op_x, op_y;

  cau_pkg::func_e       s2_func;
  logic signed [64:0]   s2_re, s2_im, s2_re_next, s2_im_next;
  logic [63:0]          s2_den, s2_den_next;
  logic signed [31:0]   s2_angle;

  always_ff @(posedge clk) begin
    s0_func  <= cau_pkg::func_e'(func);
    s0_a_re  <= a_re;
    s0_a_im  <= a_im;
    s0_b_re  <= b_re;
    s0_b_im  <= b_im;
    s0_scale <= scale;
    s0_angle <= angle;
  end

  // multiplier operand select
  always_comb begin
    op_x = s0_b_re;
    op_y = s0_b_im;
    if (s0_func == cau_pkg::FUNC_MAG) begin
      op_x = s0_a_re;
      op_y = s0_a_im;
    end else if (s0_func == cau_pkg::FUNC_SCALE) begin
      op_x = s0_scale;
      op_y = s0_scale;
    end
  end

  always_ff @(posedge clk) begin
    s1_func  <= s0_func;
    s1_a_re  <= s0_a_re;
    s1_a_im  <= s0_a_im;
    s1_b_re  <= s0_b_re;
    s1_b_im  <= s0_b_im;
    s1_angle <= s0_angle;
    s1_p0    <= s0_a_re * op_x;
    s1_p1    <= s0_a_im * op_y;
    s1_p2    <= s0_a_im * s0_b_re;
    s1_p3    <= s0_a_re * s0_b_im;
    s1_p4    <= s0_b_re * s0_b_re;
    s1_p5    <= s0_b_im * s0_b_im;
  end

  always_comb begin
    s2_re_next  = '0;
    s2_im_next  = '0;
    s2_den_next = 64'(s1_p4) + 64'(s1_p5);
    unique case (s1_func)
      cau_pkg::FUNC_MAG: begin
        s2_re_next = 65'(s1_p0) + 65'(s1_p1);
      end
      cau_pkg::FUNC_CONJ: begin
        s2_re_next = 65'(s1_a_re);
        s2_im_next = -65'(s1_a_im);
      end
      cau_pkg::FUNC_MUL: begin
        s2_re_next = 65'(s1_p0) - 65'(s1_p1);
        s2_im_next = 65'(s1_p2) + 65'(s1_p3);
      end
      cau_pkg::FUNC_DIV: begin
        s2_re_next = 65'(s1_p0) + 65'(s1_p1);
        s2_im_next = 65'(s1_p2) - 65'(s1_p3);
      end
      cau_pkg::FUNC_ADD: begin
        s2_re_next = 65'(s1_a_re) + 65'(s1_b_re);
        s2_im_next = 65'(s1_a_im) + 65'(s1_b_im);
      end
      cau_pkg::FUNC_SCALE: begin
        s2_re_next = 65'(s1_p0);
        s2_im_next = 65'(s1_p1);
      end
      default: begin
        s2_re_next = '0;
        s2_im_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s2_func  <= s1_func;
    s2_re    <= s2_re_next;
    s2_im    <= s2_im_next;
    s2_den   <= s2_den_next;
    s2_angle <= s1_angle;
  end

  always_ff @(posedge clk) begin
    fr.func     <= s2_func;
    fr.neg_re   <= s2_re[64];
    fr.neg_im   <= s2_im[64];
    fr.mag_re   <= s2_re[64] ? 64'(-s2_re) : 64'(s2_re);
    fr.mag_im   <= s2_im[64] ? 64'(-s2_im) : 64'(s2_im);
    fr.den      <= s2_den;
    fr.den_zero <= (s2_den == '0);
    fr.ang_neg  <= s2_angle[31];
    fr.ang_mag  <= s2_angle[31] ? 32'(-s2_angle) : 32'(s2_angle);
  end

endmodule

`default_nettype wire

>>> rtl/core/cau_div.sv
// pipelined restoring divider, two numerators over one denominator
`default_nettype none

module cau_div #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int STAGES    = 80
) (
  input  logic        clk,
  input  logic [63:0] num_re,
  input  logic [63:0] num_im,
  input  logic [63:0] den,
  output logic [33:0] quo_re,
  output logic [33:0] quo_im
);

  localparam int DivSteps = 64 + FRAC_BITS;
  localparam logic [33:0] QuoCap = 34'h2_0000_0000;

  typedef struct packed {
    logic [63:0] num_re;
    logic [63:0] num_im;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [33:0] quo_re;
    logic [33:0] quo_im;
    logic [63:0] den;
  } dv_t;

  dv_t st [0:STAGES];

  function automatic logic [33:0] quo_step(input logic [33:0] quo, input logic take);
    logic [34:0] q;
    q = {quo, take};
    quo_step = (q > {1'b0, QuoCap}) ? QuoCap : q[33:0];
  endfunction

  always_comb begin
    st[0].num_re = num_re;
    st[0].num_im = num_im;
    st[0].rem_re = '0;
    st[0].rem_im = '0;
    st[0].quo_re = '0;
    st[0].quo_im = '0;
    st[0].den    = den;
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    if (k < DivSteps) begin : g_step
      dv_t         nxt;
      logic [64:0] r_re, r_im;
      always_comb begin
        r_re = cau_pkg::rem_step(st[k].rem_re, st[k].num_re[63], st[k].den);
        r_im = cau_pkg::rem_step(st[k].rem_im, st[k].num_im[63], st[k].den);
        nxt        = st[k];
        nxt.num_re = st[k].num_re << 1;
        nxt.num_im = st[k].num_im << 1;
        nxt.rem_re = r_re[63:0];
        nxt.rem_im = r_im[63:0];
        nxt.quo_re = quo_step(st[k].quo_re, r_re[64]);
        nxt.quo_im = quo_step(st[k].quo_im, r_im[64]);
      end
      always_ff @(posedge clk) begin
        st[k+1] <= nxt;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        st[k+1] <= st[k];
      end
    end
  end

  assign quo_re = st[STAGES].quo_re;
  assign quo_im = st[STAGES].quo_im;

endmodule

`default_nettype wire

>>> rtl/core/cau_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none

module cau_sqrt #(
  parameter int STAGES = 80
) (
  input  logic        clk,
  input  logic [63:0] n,
  output logic [31:0] root
);

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } sq_t;

  sq_t st [0:STAGES];

  always_comb begin
    st[0].n   = n;
    st[0].res = '0;
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    if (k < cau_pkg::SQRT_STEPS) begin : g_step
      localparam logic [63:0] Tap = 64'd1 << (62 - 2 * k);
      sq_t         nxt;
      logic [64:0] trial;
      always_comb begin
        trial = {1'b0, st[k].res} + {1'b0, Tap};
        nxt   = st[k];
        if ({1'b0, st[k].n} >= trial) begin
          nxt.n   = st[k].n - trial[63:0];
          nxt.res = (st[k].res >> 1) + Tap;
        end else begin
          nxt.res = st[k].res >> 1;
        end
      end
      always_ff @(posedge clk) begin
        st[k+1] <= nxt;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        st[k+1] <= st[k];
      end
    end
  end

  assign root = st[STAGES].res[31:0];

endmodule

`default_nettype wire

>>> rtl/core/cau_phasor.sv
// angle reduction modulo two pi, quadrant fold and pipelined cordic rotation
`default_nettype none

module cau_phasor #(
  parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF,
  parameter int STAGES       = 104
) (
  input  logic                                clk,
  input  logic                                ang_neg,
  input  logic [31:0]                         ang_mag,
  output logic signed [cau_pkg::CORDIC_W-1:0] x,
  output logic signed [cau_pkg::CORDIC_W-1:0] y,
  output logic                                flip
);

  localparam int RedSteps = 93 - FRAC_BITS;
  localparam int CW       = cau_pkg::CORDIC_W;

  typedef struct packed {
    logic [63:0]          rem;
    logic [31:0]          sh;
    logic                 neg;
    logic                 flip;
    logic signed [64:0]   t;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } ph_t;

  ph_t st [0:STAGES];

  always_comb begin
    st[0].rem  = '0;
    st[0].sh   = ang_mag;
    st[0].neg  = ang_neg;
    st[0].flip = 1'b0;
    st[0].t    = '0;
    st[0].x    = '0;
    st[0].y    = '0;
    st[0].z    = '0;
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    if (k < RedSteps) begin : g_reduce
      ph_t         nxt;
      logic [64:0] r;
      always_comb begin
        r       = cau_pkg::rem_step(st[k].rem, st[k].sh[31], cau_pkg::TWO_PI_Q61);
        nxt     = st[k];
        nxt.rem = r[63:0];
        nxt.sh  = st[k].sh << 1;
      end
      always_ff @(posedge clk) begin
        st[k+1] <= nxt;
      end
    end else if (k == RedSteps) begin : g_wrap
      ph_t nxt;
      always_comb begin
        nxt = st[k];
        if (st[k].neg && st[k].rem != '0) begin
          nxt.rem = cau_pkg::TWO_PI_Q61 - st[k].rem;
        end
      end
      always_ff @(posedge clk) begin
        st[k+1] <= nxt;
      end
    end else if (k == RedSteps + 1) begin : g_fold
      ph_t                nxt;
      logic signed [64:0] r65;
      always_comb begin
        r65      = signed'({1'b0, st[k].rem});
        nxt      = st[k];
        nxt.flip = (st[k].rem > cau_pkg::HALF_PI_Q61) &&
                   (st[k].rem < cau_pkg::THREE_HALF_PI_Q61);
        if (nxt.flip) begin
          nxt.t = r65 - signed'({1'b0, cau_pkg::PI_Q61});
        end else if (st[k].rem > cau_pkg::PI_Q61) begin
          nxt.t = r65 - signed'({1'b0, cau_pkg::TWO_PI_Q61});
        end else begin
          nxt.t = r65;
        end
      end
      always_ff @(posedge clk) begin
        st[k+1] <= nxt;
      end
    end else if (k == RedSteps + 2) begin : g_load
      ph_t nxt;
      always_comb begin
        nxt   = st[k];
        // truncate toward zero from 61 to 30 fraction bits
        if (st[k].t < 0) begin
          nxt.z = CW'((st[k].t + 65'sd2147483647) >>> 31);
        end else begin
          nxt.z = CW'(st[k].t >>> 31);
        end
        nxt.x = cau_pkg::GAIN_Q30;
        nxt.y = '0;
      end
      always_ff @(posedge clk) begin
        st[k+1] <= nxt;
      end
    end else if (k < RedSteps + 3 + CORDIC_STEPS) begin : g_rotate
      localparam int Idx = k - RedSteps - 3;
      ph_t                  nxt;
      logic signed [CW-1:0] dx, dy, da;
      always_comb begin
        dx  = st[k].y >>> Idx;
        dy  = st[k].x >>> Idx;
        da  = cau_pkg::atan_q30(Idx);
        nxt = st[k];
        if (st[k].z >= 0) begin
          nxt.x = st[k].x - dx;
          nxt.y = st[k].y + dy;
          nxt.z = st[k].z - da;
        end else begin
          nxt.x = st[k].x + dx;
          nxt.y = st[k].y - dy;
          nxt.z = st[k].z + da;
        end
      end
      always_ff @(posedge clk) begin
        st[k+1] <= nxt;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        st[k+1] <= st[k];
      end
    end
  end

  assign x    = st[STAGES].x;
  assign y    = st[STAGES].y;
  assign flip = st[STAGES].flip;

endmodule

`default_nettype wire

>>> rtl/core/complex_arithmetic_unit_core.sv
// complex arithmetic unit top level: pipeline alignment, saturation and result register
`default_nettype none

// Fully pipelined fixed point complex unit (Q16.16 by default). One operation
// is taken on every clock at which start is high; busy is always low. Every
// operation runs the same pipeline: 4 front stages (input register, multiply,
// sum, sign-magnitude), S iteration stages with
// S = max(64 + FRAC_BITS, 96 - FRAC_BITS + CORDIC_STEPS), then the output
// register. done is high for one cycle, loaded with the output register, and
// res_re, res_im and status are valid in that cycle only. S is set by the
// longer of the bit-serial divider and the angle reduction followed by the
// cordic rotation.
module complex_arithmetic_unit_core #(
  parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         func,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  input  logic signed [31:0] scale,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic [1:0]         status
);

  localparam int DivSteps   = 64 + FRAC_BITS;
  localparam int PhSteps    = 96 - FRAC_BITS + CORDIC_STEPS;
  localparam int IterStages = (DivSteps > PhSteps) ? DivSteps : PhSteps;
  localparam int Depth      = cau_pkg::FRONT_STAGES + IterStages;
  localparam int Lat        = Depth + 1;
  localparam int CW         = cau_pkg::CORDIC_W;

  cau_pkg::fr_t         fr;
  cau_pkg::fr_t         dl [1:IterStages];
  cau_pkg::fr_t         al;
  logic [Depth-1:0]     vld;
  logic [33:0]          quo_re, quo_im;
  logic [31:0]          root;
  logic signed [CW-1:0] px, py;
  logic                 pflip;
  logic [CW-1:0]        ax, ay;
  logic [32:0]          s_re, s_im;
  logic                 div0;
  logic [31:0]          res_re_next, res_im_next;
  cau_pkg::status_e     status_next;

  // {saturated, value}
  function automatic logic [32:0] sat_out(input logic neg, input logic [63:0] mag);
    logic [63:0] tmp;
    tmp = 64'd0 - mag;
    if (neg) begin
      sat_out = (mag > 64'h8000_0000) ? {1'b1, 32'h8000_0000} : {1'b0, tmp[31:0]};
    end else begin
      sat_out = (mag > 64'h7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, mag[31:0]};
    end
  endfunction

  assign busy = 1'b0;

  cau_front u_front (
    .clk   (clk),
    .func  (func),
    .a_re  (a_re),
    .a_im  (a_im),
    .b_re  (b_re),
    .b_im  (b_im),
    .scale (scale),
    .angle (angle),
    .fr    (fr)
  );

  cau_div #(
    .FRAC_BITS (FRAC_BITS),
    .STAGES    (IterStages)
  ) u_div (
    .clk    (clk),
    .num_re (fr.mag_re),
    .num_im (fr.mag_im),
    .den    (fr.den),
    .quo_re (quo_re),
    .quo_im (quo_im)
  );

  cau_sqrt #(
    .STAGES (IterStages)
  ) u_sqrt (
    .clk  (clk),
    .n    (fr.mag_re),
    .root (root)
  );

  cau_phasor #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS),
    .STAGES       (IterStages)
  ) u_phasor (
    .clk     (clk),
    .ang_neg (fr.ang_neg),
    .ang_mag (fr.ang_mag),
    .x       (px),
    .y       (py),
    .flip    (pflip)
  );

  // operands kept alongside the iteration stages
  always_ff @(posedge clk) begin
    dl[1] <= fr;
    for (int k = 1; k < IterStages; k++) begin
      dl[k+1] <= dl[k];
    end
  end

  assign al = dl[IterStages];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[Depth-2:0], start & ~busy};
      done <= vld[Depth-1];
    end
  end

  always_comb begin
    ax   = px[CW-1] ? CW'(-px) : CW'(px);
    ay   = py[CW-1] ? CW'(-py) : CW'(py);
    s_re = '0;
    s_im = '0;
    div0 = 1'b0;
    unique case (al.func) inside
      cau_pkg::FUNC_MAG: begin
        s_re = sat_out(1'b0, 64'(root));
      end
      cau_pkg::FUNC_CONJ, cau_pkg::FUNC_ADD: begin
        s_re = sat_out(al.neg_re, al.mag_re);
        s_im = sat_out(al.neg_im, al.mag_im);
      end
      cau_pkg::FUNC_MUL, cau_pkg::FUNC_SCALE: begin
        s_re = sat_out(al.neg_re, al.mag_re >> FRAC_BITS);
        s_im = sat_out(al.neg_im, al.mag_im >> FRAC_BITS);
      end
      cau_pkg::FUNC_DIV: begin
        if (al.den_zero) begin
          div0 = 1'b1;
        end else begin
          s_re = sat_out(al.neg_re, 64'(quo_re));
          s_im = sat_out(al.neg_im, 64'(quo_im));
        end
      end
      cau_pkg::FUNC_EXP: begin
        s_re = sat_out(px[CW-1] ^ pflip, 64'(ax) >> (30 - FRAC_BITS));
        s_im = sat_out(py[CW-1] ^ pflip, 64'(ay) >> (30 - FRAC_BITS));
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    res_re_next = s_re[31:0];
    res_im_next = s_im[31:0];
    if (div0) begin
      status_next = cau_pkg::STATUS_DIV0;
    end else if (s_re[32] || s_im[32]) begin
      status_next = cau_pkg::STATUS_SAT;
    end else begin
      status_next = cau_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    res_re <= res_re_next;
    res_im <= res_im_next;
    status <= status_next;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(Lat) done)
    else $error("transfer did not produce a result after the pipeline latency");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == cau_pkg::STATUS_DIV0) |-> (res_re == '0 && res_im == '0))
    else $error("divide by zero result is not zero");

  a_mag_im: assert property (@(posedge clk) disable iff (rst)
    (vld[Depth-1] && al.func == cau_pkg::FUNC_MAG) |=>
      (res_im == '0 && status != cau_pkg::STATUS_DIV0))
    else $error("magnitude result has nonzero imaginary part");
`endif

endmodule

`default_nettype wire
